>>> sv/ctb_pkg.sv
// Shared types, constants and scale functions for the countdown timer bank.
`default_nettype none
package ctb_pkg;

	localparam int NUM_TIMERS_DEF = 32;
	localparam int MAX_IDX_W      = 6;
	localparam int CMD_DEPTH      = 2;
	localparam int RES_DEPTH      = 2;

	localparam logic [15:0] TENTH_SCALE  = 16'd100;
	localparam logic [15:0] SECOND_SCALE = 16'(10 * TENTH_SCALE);
	localparam logic [15:0] MINUTE_SCALE = 16'(60 * SECOND_SCALE);

	// floor(2^32 / scale); the quotient estimate is then short by at most one
	localparam logic [31:0] RECIP_TENTH  = 32'(64'd4294967296 / TENTH_SCALE);
	localparam logic [31:0] RECIP_SECOND = 32'(64'd4294967296 / SECOND_SCALE);
	localparam logic [31:0] RECIP_MINUTE = 32'(64'd4294967296 / MINUTE_SCALE);

	localparam logic [1:0] BASE_MS     = 2'd0;
	localparam logic [1:0] BASE_TENTH  = 2'd1;
	localparam logic [1:0] BASE_SECOND = 2'd2;
	localparam logic [1:0] BASE_MINUTE = 2'd3;

	typedef enum logic [2:0] {
		ACT_TICK     = 3'd0,
		ACT_START    = 3'd1,
		ACT_SET      = 3'd2,
		ACT_READ     = 3'd3,
		ACT_PAUSE    = 3'd4,
		ACT_STOP     = 3'd5,
		ACT_STOP_ALL = 3'd6,
		ACT_TAKE     = 3'd7
	} act_t;

	typedef struct packed {
		act_t                 op;
		logic [MAX_IDX_W-1:0] idx;
		logic                 idx_ok;
		logic [15:0]          tv;
		logic [1:0]           tb;
		logic                 pz;
	} cmd_t;

	typedef struct packed {
		logic [31:0] rv;
		logic [31:0] mask;
	} res_t;

	function automatic logic [15:0] scale_of(input logic [1:0] code);
		case (code)
			BASE_TENTH:  scale_of = TENTH_SCALE;
			BASE_SECOND: scale_of = SECOND_SCALE;
			BASE_MINUTE: scale_of = MINUTE_SCALE;
			default:     scale_of = 16'd1;
		endcase
	endfunction

	function automatic logic [31:0] recip_of(input logic [1:0] code);
		case (code)
			BASE_TENTH:  recip_of = RECIP_TENTH;
			BASE_SECOND: recip_of = RECIP_SECOND;
			BASE_MINUTE: recip_of = RECIP_MINUTE;
			default:     recip_of = 32'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> sv/countdown_timer_bank_top.sv
// Top level of the countdown timer bank: front end, back end and result queue.
//
//  channel   handshake          word
//  --------  -----------------  ------------------------------------------------
//  input     push / full        action, timer_index, time_value, time_base, pause
//  result    empty / pop        read_value, pending_mask
//
// Every input word yields exactly one result word, in order.
// A tick walks the count store one timer per cycle, as the store has
// a single read port and a single write port.
// A read goes through a store read, then a three-stage reciprocal divide;
// every other action is answered as it is taken from the command queue.
// Reset clears all timers at once through per-timer valid bits; no clearing pass.
// A two-word command queue and a two-word result queue let either side stall alone.
`default_nettype none
module countdown_timer_bank_top #(
	parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  action,
	input  wire logic [4:0]  timer_index,
	input  wire logic [15:0] time_value,
	input  wire logic [1:0]  time_base,
	input  wire logic        pause,
	output logic             empty,
	input  wire logic        pop,
	output logic      [31:0] read_value,
	output logic      [31:0] pending_mask
);
	import ctb_pkg::*;

	logic                    cmd_valid;
	logic                    cmd_pop;
	cmd_t                    cmd;
	logic                    res_full;
	logic                    res_push;
	res_t                    res;
	logic [$bits(res_t)-1:0] res_bits;
	res_t                    res_out;

	// Decode and queue incoming words.
	ctb_front #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.timer_index(timer_index),
		.time_value (time_value),
		.time_base  (time_base),
		.pause      (pause),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd)
	);

	// Execute one command at a time; hold off while the result queue is full.
	ctb_back #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// Hold finished result words until the consumer pops them.
	ctb_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RES_DEPTH)
	) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_bits),
		.empty (empty)
	);

	assign res_out      = res_t'(res_bits);
	assign read_value   = res_out.rv;
	assign pending_mask = res_out.mask;
endmodule
`default_nettype wire

>>> sv/ctb_fifo.sv
// Small register queue with push/full and pop/empty sides.
`default_nettype none
module ctb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] dout,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wptr_q;
	logic [AW:0]      rptr_q;

	assign empty = (wptr_q == rptr_q);
	assign full  = (wptr_q[AW] != rptr_q[AW]) && (wptr_q[AW-1:0] == rptr_q[AW-1:0]);
	assign dout  = mem_q[rptr_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wptr_q[AW-1:0]] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (push && !full) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rptr_q <= rptr_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/ctb_front.sv
// Front end: decode and range-check input words and queue them as commands.
`default_nettype none
module ctb_front #(
	parameter int NUM_TIMERS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic [2:0]   action,
	input  wire logic [4:0]   timer_index,
	input  wire logic [15:0]  time_value,
	input  wire logic [1:0]   time_base,
	input  wire logic         pause,
	output logic              cmd_valid,
	input  wire logic         cmd_pop,
	output ctb_pkg::cmd_t     cmd
);
	import ctb_pkg::*;

	cmd_t                 dec;
	logic [$bits(cmd_t)-1:0] q_bits;
	logic                 q_empty;

	always_comb begin
		dec.op     = act_t'(action);
		dec.idx    = MAX_IDX_W'(timer_index);
		// flag indexes past the bank so the back end ignores them
		dec.idx_ok = ({2'b00, timer_index} < 7'(NUM_TIMERS));
		dec.tv     = time_value;
		dec.tb     = time_base;
		dec.pz     = pause;
	end

	ctb_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (dec),
		.full  (full),
		.pop   (cmd_pop),
		.dout  (q_bits),
		.empty (q_empty)
	);

	assign cmd_valid = !q_empty;
	assign cmd       = cmd_t'(q_bits);
endmodule
`default_nettype wire

>>> sv/ctb_div.sv
// Pipelined divide of a tick count by its base scale, by reciprocal multiply.
`default_nettype none
module ctb_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_v,
	input  wire logic [31:0] x,
	input  wire logic [1:0]  code,
	output logic             out_v,
	output logic      [31:0] q
);
	import ctb_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic [63:0] prod_s1;
	logic [31:0] x_s1, x_s2;
	logic [1:0]  code_s1, code_s2;
	logic [31:0] q0_s2, qd_s2;
	logic [31:0] q_s3;
	logic [31:0] rem;
	logic [31:0] dvs;

	assign dvs = 32'(scale_of(code_s2));
	assign rem = x_s2 - qd_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(x) * 64'(recip_of(code));
		x_s1    <= x;
		code_s1 <= code;

		q0_s2   <= prod_s1[63:32];
		qd_s2   <= prod_s1[63:32] * 32'(scale_of(code_s1));
		x_s2    <= x_s1;
		code_s2 <= code_s1;

		// millisecond base passes through; else fix the estimate by one
		if (code_s2 == BASE_MS) begin
			q_s3 <= x_s2;
		end else if (rem >= dvs) begin
			q_s3 <= q0_s2 + 32'd1;
		end else begin
			q_s3 <= q0_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign out_v = v_s3;
	assign q     = q_s3;
endmodule
`default_nettype wire

>>> sv/ctb_back.sv
// Back end: timer store, tick walk, command execution and result words.
`default_nettype none
module ctb_back #(
	parameter int NUM_TIMERS = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cmd_valid,
	input  ctb_pkg::cmd_t cmd,
	output logic         cmd_pop,
	input  wire logic    res_full,
	output logic         res_push,
	output ctb_pkg::res_t res
);
	import ctb_pkg::*;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_TIMERS);

	typedef enum logic [1:0] {S_IDLE, S_TICK, S_RD, S_DIV} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [31:0]           ticks_mem [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] tvld_q;
	logic [NUM_TIMERS-1:0] pend_q;
	logic [NUM_TIMERS-1:0] paused_q;
	logic [1:0]            base_q [NUM_TIMERS];
	logic [1:0]            rd_base_q;

	logic [31:0]           rdata_s1;
	logic                  rvld_s1;
	logic                  tk_v_s1;
	logic [IDX_W-1:0]      tk_idx_s1;

	logic                  go;
	logic [IDX_W-1:0]      idx;
	logic [1:0]            scale_sel;
	logic [31:0]           load_ticks;
	logic [31:0]           cur;
	logic                  run;
	logic [31:0]           dec;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [31:0]           wr_data;
	logic [63:0]           pend_ext;
	logic                  div_out_v;
	logic [31:0]           div_q;

	assign idx        = cmd.idx[IDX_W-1:0];
	assign go         = (state_q == S_IDLE) && cmd_valid && !res_full;
	assign cmd_pop    = go;
	assign scale_sel  = (cmd.op == ACT_START) ? cmd.tb : base_q[idx];
	assign load_ticks = 32'(cmd.tv) * 32'(scale_of(scale_sel));
	assign cur        = rvld_s1 ? rdata_s1 : 32'd0;
	assign run        = (cur != 32'd0) && !paused_q[tk_idx_s1];
	assign dec        = cur - 32'd1;
	assign pend_ext   = 64'(pend_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx;
		if ((state_q == S_TICK) && (cnt_q != LAST_CNT)) begin
			rd_en   = 1'b1;
			rd_addr = cnt_q[IDX_W-1:0];
		end else if (go && (cmd.op == ACT_READ) && cmd.idx_ok) begin
			rd_en = 1'b1;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx;
		wr_data = load_ticks;
		if (tk_v_s1 && run) begin
			wr_en   = 1'b1;
			wr_addr = tk_idx_s1;
			wr_data = dec;
		end else if (go && ((cmd.op == ACT_START) || (cmd.op == ACT_SET)) && cmd.idx_ok) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ticks_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= ticks_mem[rd_addr];
			rvld_s1  <= tvld_q[rd_addr];
		end
	end

	always_comb begin
		res_push = 1'b0;
		res      = '0;
		if (div_out_v) begin
			res_push = 1'b1;
			res.rv   = div_q;
		end else if ((state_q == S_TICK) && (cnt_q == LAST_CNT)) begin
			res_push = 1'b1;
		end else if (go && (cmd.op != ACT_TICK)) begin
			if (!((cmd.op == ACT_READ) && cmd.idx_ok)) begin
				res_push = 1'b1;
			end
			if (cmd.op == ACT_TAKE) begin
				res.mask = pend_ext[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			tk_v_s1   <= 1'b0;
			tk_idx_s1 <= '0;
			tvld_q    <= '0;
			pend_q    <= '0;
			paused_q  <= '0;
			rd_base_q <= BASE_MS;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				base_q[i] <= BASE_MS;
			end
		end else begin
			tk_v_s1 <= 1'b0;
			// walk stage: mark a timer that has just run out
			if (tk_v_s1 && run && (dec == 32'd0)) begin
				pend_q[tk_idx_s1] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (go) begin
						case (cmd.op)
							ACT_TICK: begin
								cnt_q   <= '0;
								state_q <= S_TICK;
							end
							ACT_START: begin
								if (cmd.idx_ok) begin
									tvld_q[idx] <= 1'b1;
									base_q[idx] <= cmd.tb;
									pend_q[idx] <= (load_ticks == 32'd0);
								end
							end
							ACT_SET: begin
								if (cmd.idx_ok) begin
									tvld_q[idx] <= 1'b1;
								end
							end
							ACT_READ: begin
								if (cmd.idx_ok) begin
									rd_base_q <= base_q[idx];
									state_q   <= S_RD;
								end
							end
							ACT_PAUSE: begin
								if (cmd.idx_ok) begin
									paused_q[idx] <= cmd.pz;
								end
							end
							ACT_STOP: begin
								if (cmd.idx_ok) begin
									tvld_q[idx]   <= 1'b0;
									pend_q[idx]   <= 1'b0;
									paused_q[idx] <= 1'b0;
									base_q[idx]   <= BASE_MS;
								end
							end
							ACT_STOP_ALL: begin
								tvld_q   <= '0;
								pend_q   <= '0;
								paused_q <= '0;
								for (int i = 0; i < NUM_TIMERS; i++) begin
									base_q[i] <= BASE_MS;
								end
							end
							ACT_TAKE: begin
								pend_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_TICK: begin
					if (cnt_q != LAST_CNT) begin
						tk_v_s1   <= 1'b1;
						tk_idx_s1 <= cnt_q[IDX_W-1:0];
						cnt_q     <= cnt_q + 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_out_v) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	ctb_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.in_v  (state_q == S_RD),
		.x     (cur),
		.code  (rd_base_q),
		.out_v (div_out_v),
		.q     (div_q)
	);
endmodule
`default_nettype wire

>>> sv/ctb_checker.sv
// Port-level checks for the countdown timer bank, bound to the top level.
`default_nettype none
module ctb_checker #(
	parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        push,
	input wire logic        full,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [31:0] read_value,
	input wire logic [31:0] pending_mask
);
	// no result is waiting while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result queue not empty in reset");

	// the input side only fills up after taking a word
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		(!full && !push) |=> !full)
		else $error("full raised without a push");

	// a waiting result word holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(read_value) && $stable(pending_mask)))
		else $error("waiting result word changed");

	// a result word is either a read or a take events, never both
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((read_value == 32'd0) || (pending_mask == 32'd0)))
		else $error("read value and pending mask both nonzero");

	// no pending bit for a timer outside the bank
	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((pending_mask >> NUM_TIMERS) == 32'd0))
		else $error("pending bit beyond the bank");
endmodule

bind countdown_timer_bank_top ctb_checker #(.NUM_TIMERS(NUM_TIMERS)) u_ctb_checker (.*);
`default_nettype wire
